/* rtl/jhsd_pkg.sv */
// Shared types and constants of the JPEG Huffman symbol decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package jhsd_pkg;

   localparam int MaxCodeLen   = 16;
   localparam int LenSelW      = $clog2(MaxCodeLen);
   localparam int PrefixLenW   = LenSelW + 1;
   localparam int MaxSymbols   = 256;
   localparam int SymAddrW     = $clog2(MaxSymbols);
   localparam int LoadPosW     = 9;
   localparam int CodeW        = 17;
   localparam int BaseW        = 9;
   localparam int BaseSat      = 511;
   localparam int QueueDepth   = 4;
   localparam int QueueAddrW   = $clog2(QueueDepth);
   localparam int QueueCountW  = QueueAddrW + 1;
   localparam int QueueFillMax = QueueDepth - 2;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_TABLE = 2'd1,
      OP_BIT   = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic       clear;
      logic       load;
      logic       bit_valid;
      logic [7:0] table_byte;
      logic       code_bit;
   } cmd_type;

   typedef struct packed {
      logic [7:0]       count;
      logic [CodeW-1:0] first;
      logic [BaseW-1:0] base;
   } len_entry_type;

   typedef struct packed {
      logic                en;
      logic [SymAddrW-1:0] addr;
      logic [7:0]          data;
   } ram_port_type;

   typedef struct packed {
      logic [3:0]         run;
      logic [3:0]         size;
      logic signed [15:0] value;
      logic               bad_code;
   } result_type;

endpackage

`default_nettype wire

/* rtl/jhsd_sym_ram.sv */
// Symbol store: 256 x 8 synchronous RAM, one write and one read port,
// read data registered. Depends on jhsd_pkg.
`default_nettype none

module jhsd_sym_ram
   import jhsd_pkg::*;
(
   input  wire logic         clock,
   input  wire ram_port_type wr,
   input  wire ram_port_type rd,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [MaxSymbols];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/jhsd_len_table.sv */
// Per-length code table: counts, first canonical codes and symbol bases,
// built from DHT bytes; also steers symbol bytes into the symbol RAM.
// Depends on jhsd_pkg.
`default_nettype none

module jhsd_len_table
   import jhsd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire logic [LenSelW-1:0] len_sel,
   output len_entry_type           entry,
   output ram_port_type            sym_wr
);

   logic [7:0]          count_ff [MaxCodeLen];
   logic [CodeW-1:0]    first_ff [MaxCodeLen];
   logic [BaseW-1:0]    base_ff  [MaxCodeLen];
   logic [LoadPosW-1:0] load_pos_ff, load_pos_in;
   logic [CodeW-1:0]    running_ff, running_in;
   logic [BaseW-1:0]    next_base_ff, next_base_in;

   logic                is_len;
   logic [LenSelW-1:0]  len_idx;
   logic [LoadPosW-1:0] sym_idx;
   logic [LoadPosW-1:0] sym_total;
   logic [BaseW:0]      base_sum;
   logic [CodeW-1:0]    code_sum;
   logic                len_we;

   always_comb begin
      is_len    = load_pos_ff < LoadPosW'(MaxCodeLen);
      len_idx   = load_pos_ff[LenSelW-1:0];
      sym_idx   = load_pos_ff - LoadPosW'(MaxCodeLen);
      sym_total = (LoadPosW'(next_base_ff) > LoadPosW'(MaxSymbols)) ?
                  LoadPosW'(MaxSymbols) : LoadPosW'(next_base_ff);
      base_sum  = {1'b0, next_base_ff} + (BaseW+1)'(cmd.table_byte);
      code_sum  = running_ff + CodeW'(cmd.table_byte);

      len_we      = cmd.load && is_len;
      sym_wr.en   = cmd.load && !is_len && (sym_idx < sym_total);
      sym_wr.addr = sym_idx[SymAddrW-1:0];
      sym_wr.data = cmd.table_byte;

      load_pos_in  = load_pos_ff;
      running_in   = running_ff;
      next_base_in = next_base_ff;
      if (cmd.clear) begin
         load_pos_in  = '0;
         running_in   = '0;
         next_base_in = '0;
      end else if (len_we) begin
         load_pos_in  = load_pos_ff + LoadPosW'(1);
         running_in   = {code_sum[CodeW-2:0], 1'b0};
         next_base_in = (base_sum > (BaseW+1)'(BaseSat)) ?
                        BaseW'(BaseSat) : base_sum[BaseW-1:0];
      end else if (sym_wr.en) begin
         load_pos_in = load_pos_ff + LoadPosW'(1);
      end

      entry.count = count_ff[len_sel];
      entry.first = first_ff[len_sel];
      entry.base  = base_ff[len_sel];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff  <= '0;
         running_ff   <= '0;
         next_base_ff <= '0;
      end else begin
         load_pos_ff  <= load_pos_in;
         running_ff   <= running_in;
         next_base_ff <= next_base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < MaxCodeLen; i++) begin
            count_ff[i] <= '0;
            first_ff[i] <= '0;
            base_ff[i]  <= '0;
         end
      end else if (len_we) begin
         count_ff[len_idx] <= cmd.table_byte;
         first_ff[len_idx] <= running_ff;
         base_ff[len_idx]  <= next_base_ff;
      end
   end

endmodule

`default_nettype wire

/* rtl/jhsd_bit_decoder.sv */
// Bit-serial decode: prefix match against the length table, symbol fetch
// from the symbol RAM, extra-bit gathering and magnitude extension.
// Depends on jhsd_pkg.
`default_nettype none

module jhsd_bit_decoder
   import jhsd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire len_entry_type      entry,
   input  wire logic [7:0]         sym_data,
   output logic [LenSelW-1:0]      len_sel,
   output ram_port_type            sym_rd,
   output logic                    sym_wait,
   output logic                    push,
   output result_type              result
);

   logic [15:0]           prefix_ff, prefix_in;
   logic [PrefixLenW-1:0] plen_ff, plen_in;
   logic                  extra_ff, extra_in;
   logic [3:0]            prun_ff, prun_in;
   logic [3:0]            psize_ff, psize_in;
   logic [14:0]           xbits_ff, xbits_in;
   logic [3:0]            xleft_ff, xleft_in;
   logic                  wait_ff, wait_in;
   logic                  zero_ff, zero_in;

   logic [7:0]            sym;
   logic                  res_push, item_push;
   result_type            res_result, item_result;
   logic                  e_extra;
   logic [3:0]            e_run, e_size, e_left;
   logic [14:0]           e_xbits;
   logic [14:0]           xb;
   logic [15:0]           xb16, mask16;
   logic [3:0]            xl;
   logic [15:0]           pn;
   logic [PrefixLenW-1:0] ln;
   logic [CodeW-1:0]      diff;
   logic                  hit;
   logic [BaseW:0]        idx;

   always_comb begin
      sym = zero_ff ? 8'h00 : sym_data;

      // resolve a symbol fetched in the previous cycle
      res_push   = 1'b0;
      res_result = '0;
      e_extra    = extra_ff;
      e_run      = prun_ff;
      e_size     = psize_ff;
      e_left     = xleft_ff;
      e_xbits    = xbits_ff;
      if (wait_ff) begin
         if (sym[3:0] == 4'h0) begin
            res_push       = 1'b1;
            res_result.run = sym[7:4];
         end else begin
            e_extra = 1'b1;
            e_run   = sym[7:4];
            e_size  = sym[3:0];
            e_left  = sym[3:0];
            e_xbits = '0;
         end
      end

      len_sel = plen_ff[LenSelW-1:0];
      pn      = {prefix_ff[14:0], cmd.code_bit};
      ln      = plen_ff + PrefixLenW'(1);
      diff    = {1'b0, pn} - entry.first;
      hit     = (entry.count != 8'h00) && ({1'b0, pn} >= entry.first) &&
                (diff < CodeW'(entry.count));
      idx     = {1'b0, entry.base} + (BaseW+1)'(diff[7:0]);

      xb     = {e_xbits[13:0], cmd.code_bit};
      xb16   = {1'b0, xb};
      xl     = e_left - 4'd1;
      mask16 = (16'd1 << e_size) - 16'd1;

      item_push   = 1'b0;
      item_result = '0;
      sym_rd.en   = 1'b0;
      sym_rd.addr = idx[SymAddrW-1:0];
      sym_rd.data = '0;

      prefix_in = prefix_ff;
      plen_in   = plen_ff;
      extra_in  = e_extra;
      prun_in   = e_run;
      psize_in  = e_size;
      xbits_in  = e_xbits;
      xleft_in  = e_left;
      wait_in   = 1'b0;
      zero_in   = zero_ff;

      if (cmd.clear) begin
         prefix_in = '0;
         plen_in   = '0;
         extra_in  = 1'b0;
         prun_in   = '0;
         psize_in  = '0;
         xbits_in  = '0;
         xleft_in  = '0;
      end else if (cmd.bit_valid) begin
         if (e_extra) begin
            xbits_in = xb;
            xleft_in = xl;
            if (xl == 4'h0) begin
               item_push        = 1'b1;
               item_result.run  = e_run;
               item_result.size = e_size;
               item_result.value = xb16[e_size - 4'd1] ? xb16 : (xb16 - mask16);
               extra_in = 1'b0;
               prun_in  = '0;
               psize_in = '0;
               xbits_in = '0;
               xleft_in = '0;
            end
         end else if (hit) begin
            sym_rd.en = 1'b1;
            wait_in   = 1'b1;
            zero_in   = idx >= (BaseW+1)'(MaxSymbols);
            prefix_in = '0;
            plen_in   = '0;
         end else if (ln >= PrefixLenW'(MaxCodeLen)) begin
            item_push            = 1'b1;
            item_result.bad_code = 1'b1;
            prefix_in            = '0;
            plen_in              = '0;
         end else begin
            prefix_in = pn;
            plen_in   = ln;
         end
      end

      push     = res_push || item_push;
      result   = item_push ? item_result : res_result;
      sym_wait = wait_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
         plen_ff   <= '0;
         extra_ff  <= 1'b0;
         prun_ff   <= '0;
         psize_ff  <= '0;
         xbits_ff  <= '0;
         xleft_ff  <= '0;
         wait_ff   <= 1'b0;
         zero_ff   <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;
         plen_ff   <= plen_in;
         extra_ff  <= extra_in;
         prun_ff   <= prun_in;
         psize_ff  <= psize_in;
         xbits_ff  <= xbits_in;
         xleft_ff  <= xleft_in;
         wait_ff   <= wait_in;
         zero_ff   <= zero_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/jhsd_rsp_queue.sv */
// Result queue: four-entry FIFO between the decoder and the rsp channel.
// Depends on jhsd_pkg.
`default_nettype none

module jhsd_rsp_queue
   import jhsd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire result_type             push_data,
   input  wire logic                   pop,
   output logic                        out_valid,
   output result_type                  out_data,
   output logic [QueueCountW-1:0]      fill
);

   result_type             slot_ff [QueueDepth];
   logic [QueueAddrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueueAddrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCountW-1:0] count_ff, count_in;
   logic                   do_pop;

   always_comb begin
      out_valid = count_ff != '0;
      out_data  = slot_ff[rd_ptr_ff];
      fill      = count_ff;
      do_pop    = pop && out_valid;
      wr_ptr_in = push ? wr_ptr_ff + QueueAddrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QueueAddrW'(1) : rd_ptr_ff;
      count_in  = count_ff + QueueCountW'(push) - QueueCountW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/jpeg_huffman_symbol_decoder_core.sv */
// JPEG canonical Huffman symbol decoder, top level.
// Depends on jhsd_pkg, jhsd_len_table, jhsd_sym_ram, jhsd_bit_decoder,
// jhsd_rsp_queue.
//
// req channel: one item per accepted handshake. tuser carries the opcode:
// clear the table and restart loading, one DHT table byte (16 counts, then
// symbols), one coded stream bit, most significant first, or no operation.
// rsp channel: one item per decoded symbol (run, size, magnitude value) or
// per bad prefix (bad_code set after 16 bits without a match).
// Throughput: one req item per cycle while req_tready is high. A code that completes issues one
// read of the symbol RAM; its symbol is resolved in the next cycle while
// the following bit is taken in the same cycle.
// A result for a symbol with extra bits or for a bad prefix enters the queue
// in the cycle its last bit is accepted; a symbol with no extra bits enters
// it once its symbol RAM read is resolved.
// Results wait in a four-entry queue; when the receiver stalls, req_tready
// drops once the queue plus a pending symbol fetch reach three entries.
// Reset empties the queue and clears the length table and decode state;
// the symbol RAM keeps its contents and needs no clearing pass.
`default_nettype none

module jpeg_huffman_symbol_decoder_core
   import jhsd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // table_byte[7:0], code_bit[8]
   input  wire logic [1:0]  req_tuser,   // opcode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // run[3:0], size[7:4], value[23:8]
   output logic             rsp_tuser    // bad_code[0]
);

   opcode_type             opcode;
   logic                   accept;
   cmd_type                cmd;
   len_entry_type          entry;
   logic [LenSelW-1:0]     len_sel;
   ram_port_type           sym_wr;
   ram_port_type           sym_rd;
   logic [7:0]             sym_data;
   logic                   sym_wait;
   logic                   push;
   result_type             result;
   result_type             out_data;
   logic [QueueCountW-1:0] fill;

   always_comb begin
      opcode         = opcode_type'(req_tuser);
      accept         = req_tvalid && req_tready;
      cmd.clear      = accept && (opcode == OP_CLEAR);
      cmd.load       = accept && (opcode == OP_TABLE);
      cmd.bit_valid  = accept && (opcode == OP_BIT);
      cmd.table_byte = req_tdata[7:0];
      cmd.code_bit   = req_tdata[8];
      req_tready     = (fill + QueueCountW'(sym_wait)) <= QueueCountW'(QueueFillMax);
      rsp_tdata      = {out_data.value, out_data.size, out_data.run};
      rsp_tuser      = out_data.bad_code;
   end

   jhsd_len_table u_len_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .len_sel (len_sel),
      .entry   (entry),
      .sym_wr  (sym_wr)
   );

   jhsd_sym_ram u_sym_ram (
      .clock   (clock),
      .wr      (sym_wr),
      .rd      (sym_rd),
      .rd_data (sym_data)
   );

   jhsd_bit_decoder u_bit_decoder (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .entry    (entry),
      .sym_data (sym_data),
      .len_sel  (len_sel),
      .sym_rd   (sym_rd),
      .sym_wait (sym_wait),
      .push     (push),
      .result   (result)
   );

   jhsd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .fill      (fill)
   );

endmodule

`default_nettype wire
